/* rtl/tlssni_pkg.sv */
// Package for the TLS ClientHello server-name extractor.
// Holds parse phases, position width and the result record type; no dependencies.
`default_nettype none
package tlssni_pkg;
    localparam int OFFSET_BITS = 18;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0] NAME_HOST = 8'h00;
    localparam int HDR_LAST = 8;
    localparam int VER_RAND_LEN = 34;

    typedef enum logic [3:0] {
        PH_HDR, PH_SKIP, PH_SID, PH_CS, PH_COMP, PH_EXTS, PH_EXT_TYPE, PH_EXT_LEN,
        PH_LIST_LEN, PH_ENT_TYPE, PH_ENT_LEN, PH_NAME, PH_DONE, PH_EXT_LOOP, PH_ENT_LOOP
    } phase_t;

    // One queued result: kind, name byte, found, name length, last
    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        found;
        logic [15:0] name_length;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

/* rtl/tlssni_parser.sv */
// Front part: parses payload bytes and produces up to two results per byte.
// Depends on tlssni_pkg.
`default_nettype none
module tlssni_parser
    import tlssni_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_eop,
    output result_t          res0,
    output result_t          res1,
    output logic [1:0]       res_count
);
    localparam int PW = OFFSET_BITS;
    localparam int XW = OFFSET_BITS + 1;

    logic [15:0] max_size_reg;
    phase_t      phase_reg, phase_next, resume_reg, resume_next;
    logic [PW-1:0] pos_reg, pos_next, exts_end_reg, exts_end_next;
    logic [PW-1:0] ext_end_reg, ext_end_next, list_end_reg, list_end_next;
    logic [15:0] remain_reg, remain_next, cap_len_reg, cap_len_next;
    logic [7:0]  high_reg, high_next;
    logic hdr_ok_reg, hdr_ok_next, bound_reg, bound_next, done_reg, done_next;
    logic have_high_reg, have_high_next, match_reg, match_next;

    logic [PW-1:0] nxt;
    logic [15:0]   v;
    logic [XW-1:0] nxt_v, nxt4, nxt3;
    logic [PW-1:0] ext_gap;
    logic          name_emit;

    always_comb begin
        nxt = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
        v = {high_reg, in_byte};
        nxt_v = {1'b0, nxt} + {{(XW-16){1'b0}}, v};
        nxt4 = {1'b0, nxt} + XW'(4);
        nxt3 = {1'b0, nxt} + XW'(3);
        ext_gap = (ext_end_reg > nxt) ? ext_end_reg - nxt : '0;
    end

    // Parse step; loop pseudo-phases are resolved at position nxt
    always_comb begin
        phase_t tgt;
        logic   go;
        logic [PW-1:0] skip_n;
        phase_next = phase_reg; resume_next = resume_reg; pos_next = pos_reg;
        exts_end_next = exts_end_reg; ext_end_next = ext_end_reg;
        list_end_next = list_end_reg; remain_next = remain_reg;
        cap_len_next = cap_len_reg; high_next = high_reg; hdr_ok_next = hdr_ok_reg;
        bound_next = bound_reg; done_next = done_reg; have_high_next = have_high_reg;
        match_next = match_reg; name_emit = 1'b0;
        go = 1'b0; tgt = PH_DONE; skip_n = '0;
        if (in_fire) begin
            unique case (phase_reg)
                PH_HDR: begin
                    if ((pos_reg == '0 && in_byte != REC_HANDSHAKE) ||
                        (pos_reg == PW'(5) && in_byte != HS_CLIENT_HELLO)) begin
                        hdr_ok_next = 1'b0; phase_next = PH_DONE;
                    end else if (pos_reg >= PW'(HDR_LAST)) begin
                        go = 1'b1; skip_n = PW'(VER_RAND_LEN); tgt = PH_SID;
                    end
                end
                PH_SKIP: begin
                    if (remain_reg <= 16'd1) begin
                        remain_next = '0; go = 1'b1; tgt = resume_reg;
                    end else begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                PH_SID: begin go = 1'b1; skip_n = PW'(in_byte); tgt = PH_CS; end
                PH_CS: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin go = 1'b1; skip_n = PW'(v); tgt = PH_COMP; end
                end
                PH_COMP: begin go = 1'b1; skip_n = PW'(in_byte); tgt = PH_EXTS; end
                PH_EXTS: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin
                        if (nxt_v > XW'(POS_MAX)) begin
                            bound_next = 1'b1; exts_end_next = POS_MAX;
                        end else begin
                            exts_end_next = nxt_v[PW-1:0];
                        end
                        go = 1'b1; tgt = PH_EXT_LOOP;
                    end
                end
                PH_EXT_TYPE: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin
                        have_high_next = 1'b0; match_next = (v == EXT_SERVER_NAME);
                        phase_next = PH_EXT_LEN;
                    end
                end
                PH_EXT_LEN: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin
                        have_high_next = 1'b0;
                        if (nxt_v > {1'b0, exts_end_reg}) begin
                            bound_next = 1'b1; phase_next = PH_DONE;
                        end else begin
                            ext_end_next = nxt_v[PW-1:0];
                            if (match_reg && v >= 16'd2) begin
                                list_end_next = nxt_v[PW-1:0]; phase_next = PH_LIST_LEN;
                            end else begin
                                go = 1'b1; skip_n = PW'(v); tgt = PH_EXT_LOOP;
                            end
                        end
                    end
                end
                PH_LIST_LEN: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin go = 1'b1; tgt = PH_ENT_LOOP; end
                end
                PH_ENT_TYPE: begin
                    match_next = (in_byte == NAME_HOST); phase_next = PH_ENT_LEN;
                end
                PH_ENT_LEN: begin
                    if (!have_high_reg) begin high_next = in_byte; have_high_next = 1'b1; end
                    else begin
                        have_high_next = 1'b0;
                        if (nxt_v > {1'b0, list_end_reg}) begin
                            go = 1'b1; skip_n = ext_gap; tgt = PH_EXT_LOOP;
                        end else if (match_reg && v != '0 && v < max_size_reg) begin
                            cap_len_next = v; remain_next = v; phase_next = PH_NAME;
                        end else begin
                            go = 1'b1; skip_n = PW'(v); tgt = PH_ENT_LOOP;
                        end
                    end
                end
                PH_NAME: begin
                    name_emit = 1'b1;
                    if (remain_reg <= 16'd1) begin
                        remain_next = '0; done_next = 1'b1; phase_next = PH_DONE;
                    end else begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                default: phase_next = PH_DONE;
            endcase
            // Skip n bytes, or enter target phase now when n is zero
            if (go) begin
                have_high_next = 1'b0;
                if (skip_n != '0) begin
                    phase_next = PH_SKIP; remain_next = skip_n[15:0]; resume_next = tgt;
                end else if (tgt == PH_EXT_LOOP) begin
                    phase_next = (nxt4 <= {1'b0, exts_end_next}) ? PH_EXT_TYPE : PH_DONE;
                end else if (tgt == PH_ENT_LOOP) begin
                    if (nxt3 <= {1'b0, list_end_reg}) phase_next = PH_ENT_TYPE;
                    else if (ext_gap != '0) begin
                        phase_next = PH_SKIP; remain_next = ext_gap[15:0];
                        resume_next = PH_EXT_LOOP;
                    end else begin
                        phase_next = (nxt4 <= {1'b0, exts_end_next}) ? PH_EXT_TYPE : PH_DONE;
                    end
                end else begin
                    phase_next = tgt;
                end
            end
            pos_next = nxt;
            // Clear parse state after the verdict
            if (in_eop) begin
                phase_next = PH_HDR; resume_next = PH_HDR; pos_next = '0;
                exts_end_next = '0; ext_end_next = '0; list_end_next = '0;
                remain_next = '0; cap_len_next = '0; high_next = '0;
                hdr_ok_next = 1'b1; bound_next = 1'b0; done_next = 1'b0;
                have_high_next = 1'b0; match_next = 1'b0;
            end
        end
    end

    // Build result records
    always_comb begin
        logic found;
        found = hdr_ok_reg && (done_reg || (name_emit && remain_reg <= 16'd1)) &&
                !bound_reg && !bound_next &&
                (exts_end_reg <= nxt) && (pos_reg != POS_MAX || exts_end_reg <= pos_reg);
        res0 = '0; res1 = '0;
        res1.kind = 1'b1; res1.found = found;
        res1.name_length = found ? cap_len_reg : '0; res1.last = 1'b1;
        if (name_emit) begin
            res0.name_byte = in_byte; res0.last = !in_eop;
            res_count = in_eop ? 2'd2 : 2'd1;
        end else begin
            res0 = res1;
            res_count = in_eop ? 2'd1 : 2'd0;
        end
        if (!in_fire) res_count = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= 16'd256;
            phase_reg <= PH_HDR; resume_reg <= PH_HDR; pos_reg <= '0;
            exts_end_reg <= '0; ext_end_reg <= '0; list_end_reg <= '0;
            remain_reg <= '0; cap_len_reg <= '0; high_reg <= '0;
            hdr_ok_reg <= 1'b1; bound_reg <= 1'b0; done_reg <= 1'b0;
            have_high_reg <= 1'b0; match_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) max_size_reg <= cfg_wr_data;
            phase_reg <= phase_next; resume_reg <= resume_next; pos_reg <= pos_next;
            exts_end_reg <= exts_end_next; ext_end_reg <= ext_end_next;
            list_end_reg <= list_end_next; remain_reg <= remain_next;
            cap_len_reg <= cap_len_next; high_reg <= high_next;
            hdr_ok_reg <= hdr_ok_next; bound_reg <= bound_next; done_reg <= done_next;
            have_high_reg <= have_high_next; match_reg <= match_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/tlssni_outq.sv */
// Back part: four-entry result queue feeding the output channel.
// Depends on tlssni_pkg.
`default_nettype none
module tlssni_outq
    import tlssni_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  result_t         wr0,
    input  result_t         wr1,
    input  wire logic [1:0] wr_count,
    output logic            room,
    output logic            out_valid,
    output result_t         out_data,
    input  wire logic       out_ready
);
    result_t    mem_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // Leave room for two pushes
    assign room      = cnt_reg <= 3'd2;

    always_ff @(posedge aclk) begin
        if (wr_count != '0) mem_reg[wr_reg] <= wr0;
        if (wr_count == 2'd2) mem_reg[wr_reg + 2'd1] <= wr1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + wr_count;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, wr_count} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/tls_client_hello_sni_extract_top.sv */
// Top level of the TLS ClientHello server-name extractor.
// Results are registered into the result queue at the input edge and read out from it.
// Throughput: one payload byte per cycle; input stalls only when the
// four-entry result queue cannot take two more results.
// Reset: aresetn synchronous active low; clears parse state, queue, max_name_size=256.
`default_nettype none
module tls_client_hello_sni_extract_top
    import tlssni_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_payload
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] name_byte, [8] found, [24:9] name_length
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // last
);
    result_t    r0, r1, q;
    logic [1:0] cnt;
    logic       room;

    assign s_tready = room;

    tlssni_parser u_parser (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .in_fire(s_tvalid && room), .in_byte(s_tdata), .in_eop(s_tlast),
        .res0(r0), .res1(r1), .res_count(cnt)
    );

    tlssni_outq u_outq (
        .aclk, .aresetn, .wr0(r0), .wr1(r1), .wr_count(cnt), .room,
        .out_valid(m_tvalid), .out_data(q), .out_ready(m_tready)
    );

    assign m_tdata = {7'b0, q.name_length, q.found, q.name_byte};
    assign m_tuser = q.kind;
    assign m_tlast = q.last;
endmodule
`default_nettype wire
